// ----- sv/gfhs_pkg.sv -----
// gfhs_pkg: shared constants and types for the gated frequency hysteresis switch.
// Register map, field widths and reset values. No dependencies.

package gfhs_pkg;

  localparam int unsigned TickW   = 8;
  localparam int unsigned GateW   = 16;
  localparam int unsigned CountW  = 16;
  localparam int unsigned LockW   = 8;
  localparam int unsigned AddrW   = 5;
  localparam int unsigned DataW   = 32;
  localparam int unsigned InDataW  = 8;
  localparam int unsigned OutDataW = 24;

  localparam logic [TickW-1:0]  TickMsRst   = 8'd16;
  localparam logic [GateW-1:0]  GateMsRst   = 16'd300;
  localparam logic [CountW-1:0] RiseCntRst  = 16'd18;
  localparam logic [CountW-1:0] FallCntRst  = 16'd15;
  localparam logic [LockW-1:0]  LockLenRst  = 8'd1;

  localparam logic [CountW-1:0] CountMax    = '1;

  // Register index = paddr[4:2]
  typedef enum logic [2:0] {
    REG_TICK_MS   = 3'd0,
    REG_GATE_MS   = 3'd1,
    REG_RISE_CNT  = 3'd2,
    REG_FALL_CNT  = 3'd3,
    REG_LOCK_LEN  = 3'd4
  } cfg_reg_e;

  typedef struct packed {
    logic              locked_out;
    logic [CountW-1:0] gate_count;
    logic              gate_closed;
    logic              out_level;
  } result_t;

endpackage

// ----- sv/gated_frequency_hysteresis_switch.sv -----
// gated_frequency_hysteresis_switch: edge counter over timed gates, with a
// hysteresis output and lockout. Uses gfhs_pkg.
//
//  channel   | dir | handshake               | payload
//  ----------+-----+-------------------------+----------------------------------
//  s_axis    | in  | s_axis_tvalid/tready    | tdata: sample_lvl, tick
//  m_axis    | out | m_axis_tvalid/tready    | tdata: out_level, gate_closed,
//            |     |                         |        gate_count, locked_out
//  apb       | in  | psel/penable, pready=1  | 5 regs at 4*i, 32-bit data
//
// One beat per clock unless the output stalls. The whole state update (edge
// count, gate accumulator, hysteresis decision) is combinational from the
// accepted beat into the result register; throughput is set by that path.
// Output register: a new beat is taken whenever the result register is empty
// or being drained; a stalled output holds its beat and stops only input.
// Reset (rst_ni, async low) clears all state but the result data and loads the register defaults.

module gated_frequency_hysteresis_switch (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // input stream
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  input  logic [gfhs_pkg::InDataW-1:0]    s_axis_tdata,   // [0] sample_lvl, [1] tick, rest 0
  // output stream
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  output logic [gfhs_pkg::OutDataW-1:0]   m_axis_tdata,   // [0] out_level, [1] gate_closed,
                                                          // [17:2] gate_count,
                                                          // [18] locked_out, rest 0
  // config
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [gfhs_pkg::AddrW-1:0]      paddr,
  input  logic [gfhs_pkg::DataW-1:0]      pwdata,
  output logic [gfhs_pkg::DataW-1:0]      prdata,
  output logic                            pready
);
  import gfhs_pkg::*;

  // ---------------------------------------------------------------- config
  logic [TickW-1:0]  tick_ms_q;
  logic [GateW-1:0]  gate_ms_q;
  logic [CountW-1:0] rise_cnt_q;
  logic [CountW-1:0] fall_cnt_q;
  logic [LockW-1:0]  lock_len_q;
  logic              cfg_wr;
  cfg_reg_e          cfg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel & penable & pwrite & pready;
  assign cfg_idx = cfg_reg_e'(paddr[AddrW-1:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tick_ms_q  <= TickMsRst;
      gate_ms_q  <= GateMsRst;
      rise_cnt_q <= RiseCntRst;
      fall_cnt_q <= FallCntRst;
      lock_len_q <= LockLenRst;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_TICK_MS:  tick_ms_q  <= pwdata[TickW-1:0];
        REG_GATE_MS:  gate_ms_q  <= pwdata[GateW-1:0];
        REG_RISE_CNT: rise_cnt_q <= pwdata[CountW-1:0];
        REG_FALL_CNT: fall_cnt_q <= pwdata[CountW-1:0];
        REG_LOCK_LEN: lock_len_q <= pwdata[LockW-1:0];
        default: ;  // unmapped: ignored
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      REG_TICK_MS:  prdata = DataW'(tick_ms_q);
      REG_GATE_MS:  prdata = DataW'(gate_ms_q);
      REG_RISE_CNT: prdata = DataW'(rise_cnt_q);
      REG_FALL_CNT: prdata = DataW'(fall_cnt_q);
      REG_LOCK_LEN: prdata = DataW'(lock_len_q);
      default:      prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------- handshake
  logic in_acc, out_valid_q;
  result_t res_q, res_d;

  assign s_axis_tready = ~out_valid_q | m_axis_tready;
  assign in_acc        = s_axis_tvalid & s_axis_tready;
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {{(OutDataW - $bits(result_t)){1'b0}}, res_q};

  // ---------------------------------------------------------------- state
  logic              prev_lvl_q, prev_lvl_d;
  logic [CountW-1:0] tally_q, tally_d;
  logic [GateW-1:0]  elapsed_q, elapsed_d;
  logic [LockW-1:0]  lock_left_q, lock_left_d;
  logic              sw_q, sw_d;

  logic              in_lvl, in_tick;
  logic [CountW-1:0] tally_inc;
  logic [GateW:0]    sum, rem;
  logic              closes;

  assign in_lvl  = s_axis_tdata[0];
  assign in_tick = s_axis_tdata[1];

  always_comb begin
    // rising edge counted first, saturating
    tally_inc = tally_q;
    if (!prev_lvl_q && in_lvl && (tally_q != CountMax)) tally_inc = tally_q + 1'b1;

    sum    = (GateW+1)'(elapsed_q) + (GateW+1)'(tick_ms_q);
    closes = in_tick && (sum >= (GateW+1)'(gate_ms_q));
    rem    = closes ? sum - (GateW+1)'(gate_ms_q) : sum;

    prev_lvl_d  = in_lvl;
    tally_d     = tally_inc;
    elapsed_d   = elapsed_q;
    lock_left_d = lock_left_q;
    sw_d        = sw_q;

    if (in_tick) elapsed_d = rem[GateW] ? '1 : rem[GateW-1:0];

    if (closes) begin
      tally_d = '0;
      if (lock_left_q != '0) begin
        lock_left_d = lock_left_q - 1'b1;
      end else if (!sw_q) begin
        if (tally_inc >= rise_cnt_q) begin
          sw_d        = 1'b1;
          lock_left_d = lock_len_q;
        end
      end else if (tally_inc <= fall_cnt_q) begin
        sw_d        = 1'b0;
        lock_left_d = lock_len_q;
      end
    end

    res_d.out_level   = sw_d;
    res_d.gate_closed = closes;
    res_d.gate_count  = closes ? tally_inc : '0;
    res_d.locked_out  = (lock_left_d != '0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_lvl_q  <= 1'b0;
      tally_q     <= '0;
      elapsed_q   <= '0;
      lock_left_q <= '0;
      sw_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_acc) begin
        prev_lvl_q  <= prev_lvl_d;
        tally_q     <= tally_d;
        elapsed_q   <= elapsed_d;
        lock_left_q <= lock_left_d;
        sw_q        <= sw_d;
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) res_q <= res_d;
  end

  // ---------------------------------------------------------------- checks
  a_count_only_on_close: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !res_q.gate_closed) |-> (res_q.gate_count == '0))
    else $error("gate_count nonzero without a closed gate");

  a_no_tick_holds_acc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && !in_tick) |=> $stable(elapsed_q))
    else $error("accumulator moved without a tick");

  a_close_clears_tally: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && closes) |=> (tally_q == '0))
    else $error("edge tally not cleared at gate close");

  a_lock_flag_tracks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> (res_q.locked_out == (lock_left_q != '0)) && (res_q.out_level == sw_q))
    else $error("result disagrees with stored state");

endmodule

// ----- dv/gated_frequency_hysteresis_switch_test.sv -----
// Self-checking testbench for gated_frequency_hysteresis_switch: streams sample beats,
// predicts every result beat in a scoreboard class and compares field by field.
// Depends on gfhs_pkg and the gated_frequency_hysteresis_switch RTL.

module gated_frequency_hysteresis_switch_test;
  timeunit 1ns;
  timeprecision 1ps;

  import gfhs_pkg::*;

  localparam int unsigned CycleLimit = 2_000_000;
  localparam int unsigned MaxReports = 10;
  localparam int unsigned NumRegs    = 5;   // valid register slots
  localparam int unsigned RegSlots   = 8;   // slots the address decodes
  localparam int unsigned HoldEvery  = 600; // results between long sink stalls
  localparam int unsigned LongHold   = 120; // cycles of one long sink stall
  localparam int unsigned BurstPairs = 20;  // rise/fall pairs packed into one gate
  // directed pairs, two bits each from bit 0 up: [0] level, [1] tick
  localparam logic [31:0] DirSeq     = 32'hB391_BEC4;

  // Predicts one result beat per sample beat and checks what comes out.
  class gate_result_board;
    result_t            expected_results[$];
    int unsigned        errors;
    // register copies
    logic [TickW-1:0]   tick_len;
    logic [GateW-1:0]   gate_len;
    logic [CountW-1:0]  rise_at;
    logic [CountW-1:0]  fall_at;
    logic [LockW-1:0]   lock_len;
    // switch state
    logic               last_level;
    logic [CountW-1:0]  edges;
    logic [GateW-1:0]   elapsed;
    logic [LockW-1:0]   lock_left;
    logic               level_high;

    function new();
      tick_len   = TickMsRst;
      gate_len   = GateMsRst;
      rise_at    = RiseCntRst;
      fall_at    = FallCntRst;
      lock_len   = LockLenRst;
      last_level = 1'b0;
      edges      = '0;
      elapsed    = '0;
      lock_left  = '0;
      level_high = 1'b0;
      errors     = 0;
    endfunction

    function void set_reg(logic [2:0] idx, logic [DataW-1:0] value);
      case (idx)
        REG_TICK_MS:  tick_len = value[TickW-1:0];
        REG_GATE_MS:  gate_len = value[GateW-1:0];
        REG_RISE_CNT: rise_at  = value[CountW-1:0];
        REG_FALL_CNT: fall_at  = value[CountW-1:0];
        REG_LOCK_LEN: lock_len = value[LockW-1:0];
        default: ; // unmapped slot, no effect
      endcase
    endfunction

    function void note_sample(logic level, logic tick);
      result_t     want;
      int unsigned sum;
      want = '0;
      // edge goes into the gate that this beat may close
      if (!last_level && level && edges != CountMax) edges++;
      last_level = level;
      if (tick) begin
        sum = elapsed + tick_len;
        if (sum >= gate_len) begin
          sum -= gate_len;          // one gate per tick at most
          want.gate_closed = 1'b1;
          want.gate_count  = edges;
          edges            = '0;
          if (lock_left != 0) begin
            lock_left--;            // locked gate: no decision
          end else if (!level_high) begin
            if (want.gate_count >= rise_at) begin
              level_high = 1'b1;
              lock_left  = lock_len;
            end
          end else if (want.gate_count <= fall_at) begin
            level_high = 1'b0;
            lock_left  = lock_len;
          end
        end
        elapsed = ((sum >> GateW) != 0) ? '1 : sum[GateW-1:0];
      end
      want.out_level  = level_high;
      want.locked_out = (lock_left != 0);
      expected_results.push_back(want);
    endfunction

    function void check_result(logic [OutDataW-1:0] beat);
      result_t want;
      result_t got;
      got = beat[$bits(result_t)-1:0];
      if (expected_results.size() == 0) begin
        errors++;
        if (errors <= MaxReports) $display("result beat %h with nothing outstanding", beat);
        return;
      end
      want = expected_results.pop_front();
      if (got.out_level !== want.out_level || got.gate_closed !== want.gate_closed ||
          got.gate_count !== want.gate_count || got.locked_out !== want.locked_out) begin
        errors++;
        if (errors <= MaxReports)
          $display({"mismatch: exp out=%0b closed=%0b count=%0d locked=%0b",
                    " | got out=%0b closed=%0b count=%0d locked=%0b"},
                   want.out_level, want.gate_closed, want.gate_count, want.locked_out,
                   got.out_level, got.gate_closed, got.gate_count, got.locked_out);
      end
    endfunction
  endclass

  // DUT inputs start known
  logic                clk_i         = 1'b0;
  logic                rst_ni        = 1'b0;
  logic                s_axis_tvalid = 1'b0;
  logic [InDataW-1:0]  s_axis_tdata  = '0;
  logic                m_axis_tready = 1'b0;
  logic                psel          = 1'b0;
  logic                penable       = 1'b0;
  logic                pwrite        = 1'b0;
  logic [AddrW-1:0]    paddr         = '0;
  logic [DataW-1:0]    pwdata        = '0;

  logic                s_axis_tready;
  logic                m_axis_tvalid;
  logic [OutDataW-1:0] m_axis_tdata;
  logic [DataW-1:0]    prdata;
  logic                pready;

  gate_result_board    board;
  bit                  steady;         // no random idling on either side
  int unsigned         results_seen = 0;
  int unsigned         hold_marks   = 0;
  int unsigned         rx_wait      = 0;
  int unsigned         rx_roll;
  int unsigned         cycle_count  = 0;

  gated_frequency_hysteresis_switch DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),   // [0] sample_lvl, [1] tick, rest 0
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),   // [0] out_level, [1] gate_closed, [17:2] gate_count,
                                     // [18] locked_out, rest 0
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // run watchdog
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // result monitor: every accepted beat goes to the scoreboard
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      board.check_result(m_axis_tdata);
      results_seen <= results_seen + 1;
    end
  end

  // sink pacing: random stalls, plus two long hold-offs while the source keeps
  // offering, so the output register fills and backpressure reaches tready
  always @(posedge clk_i) begin
    if (rx_wait != 0) begin
      rx_wait       <= rx_wait - 1;
      m_axis_tready <= 1'b0;
    end else if (hold_marks < 2 && results_seen >= (hold_marks + 1) * HoldEvery) begin
      hold_marks    <= hold_marks + 1;
      rx_wait       <= LongHold - 1;
      m_axis_tready <= 1'b0;
    end else if (steady) begin
      m_axis_tready <= 1'b1;
    end else begin
      rx_roll = $urandom_range(0, 99);
      if (rx_roll < 70) begin
        m_axis_tready <= 1'b1;
      end else if (rx_roll < 95) begin
        m_axis_tready <= 1'b0;
        rx_wait       <= $urandom_range(0, 2);
      end else begin
        m_axis_tready <= 1'b0;
        rx_wait       <= $urandom_range(7, 29);
      end
    end
  end

  // source gap: mostly none or short, now and then long
  function automatic int unsigned pick_gap();
    int unsigned roll;
    if (steady) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 60) return 0;
    if (roll < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // one sample beat; returns at the edge that accepted it
  task automatic send_sample(input logic level, input logic tick);
    int unsigned gap;
    gap = pick_gap();
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= InDataW'({tick, level});
    do @(posedge clk_i); while (!s_axis_tready);
    board.note_sample(level, tick);
  endtask

  task automatic send_random(input int unsigned n, input int unsigned high_pct,
                             input int unsigned tick_pct);
    for (int unsigned i = 0; i < n; i++)
      send_sample($urandom_range(0, 99) < high_pct, $urandom_range(0, 99) < tick_pct);
  endtask

  // stop offering and wait until every predicted result has been taken
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    while (board.expected_results.size() != 0) @(posedge clk_i);
  endtask

  // setup + access; psel stays up between back-to-back writes
  task automatic write_reg(input logic [2:0] idx, input logic [DataW-1:0] value,
                           input bit last);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= AddrW'({idx, 2'b00});
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    board.set_reg(idx, value);
    if (last) begin
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
    end
  endtask

  task automatic write_settings(input int unsigned tick_ms, input int unsigned gate_ms,
                                input int unsigned rise, input int unsigned fall,
                                input int unsigned lock);
    write_reg(REG_TICK_MS,  tick_ms, 1'b0);
    write_reg(REG_GATE_MS,  gate_ms, 1'b0);
    write_reg(REG_RISE_CNT, rise,    1'b0);
    write_reg(REG_FALL_CNT, fall,    1'b0);
    write_reg(REG_LOCK_LEN, lock,    1'b1);
  endtask

  initial begin
    int unsigned t;
    int unsigned k;
    int unsigned rise;
    int unsigned fall;
    board  = new();
    steady = 1'b0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset settings: all four level/tick combinations
    for (int i = 0; i < 4; i++) send_sample(i[0], i[1]);
    settle();

    // short gate; leftover accumulator closes a gate on several ticks in a row,
    // edges land on the closing beat, lockout of one gate
    write_settings(2, 4, 2, 1, 1);
    for (int i = 0; i < 16; i++) send_sample(DirSeq[2*i], DirSeq[2*i+1]);
    settle();

    // unmapped slots must not touch anything
    for (int unsigned i = NumRegs; i < RegSlots; i++)
      write_reg(3'(i), $urandom, i == RegSlots - 1);

    for (int p = 0; p < 11; p++) begin
      case (p)
        0: begin
          // zero gate: every tick closes and the accumulator runs into saturation;
          // rise 0 / fall max with no lockout toggles on every gate
          write_settings(255, 0, 0, 65535, 0);
          send_random(300, 50, 90);
        end
        1: begin
          // saturated accumulator drains one gate per tick
          steady = 1'b1;
          write_settings(7, 300, 3, 1, 2);
          send_random(100, 50, 50);
        end
        2: begin
          // zero tick length never advances the accumulator
          write_settings(0, 1, 0, 0, 0);
          send_random(60, 50, 60);
        end
        3: begin
          // longest lockout after a forced transition
          write_settings(1, 1, 0, 65535, 255);
          send_random(280, 50, 100);
        end
        4: begin
          // longest gate, thresholds at the far ends
          write_settings(255, 65535, 65535, 0, 0);
          send_random(270, 40, 100);
        end
        default: begin
          steady = (p % 3 == 1);
          t    = $urandom_range(1, 255);
          k    = $urandom_range(1, 6);
          rise = $urandom_range(0, 2 * k + 1);
          fall = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 65535)
                                             : $urandom_range(0, rise);
          write_settings(t, t * k - $urandom_range(0, t - 1), rise, fall,
                         $urandom_range(0, 3));
          send_random(60, $urandom_range(10, 90), $urandom_range(25, 100));
        end
      endcase
      settle();
      steady = 1'b0;
    end

    // dense burst of rising edges inside one gate, then one closing tick
    steady = 1'b1;
    write_settings(1, 1, 65535, 65534, 0);
    send_sample(1'b0, 1'b0);
    for (int unsigned i = 0; i < BurstPairs; i++) begin
      send_sample(1'b1, 1'b0);
      send_sample(1'b0, 1'b0);
    end
    send_sample(1'b1, 1'b1);
    steady = 1'b0;
    send_random(20, 50, 50);

    settle();
    repeat (4) @(posedge clk_i);
    if (board.errors == 0 && board.expected_results.size() == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

endmodule
